/* rtl/rbd_pkg.sv */
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int CHAN_W      = 8;
  localparam int PAIR_W      = CHAN_W + 1;
  localparam int QUAD_W      = 11;
  localparam int QUAD_RESET  = 1024;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // Per-channel sums of one horizontal pair.
  typedef struct packed {
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] red;
  } pair_sum_t;

  // What the current source pixel does at its scan position.
  typedef struct packed {
    logic      wr;
    logic      rd;
    logic      result;
    logic      last;
    pair_sum_t pair;
  } step_t;

endpackage

/* rtl/rbd_in_if.sv */
`timescale 1ns / 1ps

interface rbd_in_if import rbd_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);

endinterface

/* rtl/rbd_out_if.sv */
`timescale 1ns / 1ps

interface rbd_out_if import rbd_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic [CHAN_W-1:0] alpha_out;
  logic              last_of_image;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output last_of_image, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input last_of_image, output ready);

endinterface

/* rtl/rbd_line_store.sv */
`timescale 1ns / 1ps

module rbd_line_store import rbd_pkg::*; #(
  parameter int AW    = 11,
  parameter int DEPTH = 2048
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  pair_sum_t     wdata_i,
  output pair_sum_t     rdata_o
);

  pair_sum_t mem [DEPTH];
  pair_sum_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rbd_scan.sv */
`timescale 1ns / 1ps

module rbd_scan import rbd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int QIW       = 10,
  parameter int CW        = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  logic              cfg_we_i,
  input  logic [QUAD_W-1:0] cfg_wdata_i,
  output step_t             step_o,
  output logic [CW-2:0]     addr_o
);

  localparam int QMAX  = MAX_WIDTH / 4;
  localparam int RST_Q = (QUAD_RESET > QMAX) ? QMAX : QUAD_RESET;

  logic [CW-1:0]  col_q, col_d;
  logic [CW-1:0]  row_q, row_d;
  logic [CW-1:0]  wlast_q, wlast_d;
  logic [QIW-1:0] qm1;
  pixel_t         held_q;
  logic           col_end, row_end;

  // Width register holds W - 1 with the quad count clamped to 1..QMAX.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      qm1 = '0;
    end else if (32'(cfg_wdata_i) > QMAX) begin
      qm1 = QIW'(QMAX - 1);
    end else begin
      qm1 = QIW'(cfg_wdata_i - QUAD_W'(1));
    end
    wlast_d = {qm1, 2'b11};
  end

  assign col_end = (col_q >= wlast_q);
  assign row_end = (row_q >= wlast_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : row_q + CW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      wlast_q <= CW'(RST_Q * 4 - 1);
      held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        wlast_q <= wlast_d;
      end
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        if (!col_q[0]) begin
          held_q <= '{blue: blue_i, green: green_i, red: red_i};
        end
      end
    end
  end

  always_comb begin
    step_o.pair.red   = {1'b0, held_q.red}   + {1'b0, red_i};
    step_o.pair.green = {1'b0, held_q.green} + {1'b0, green_i};
    step_o.pair.blue  = {1'b0, held_q.blue}  + {1'b0, blue_i};
    step_o.wr         = col_q[0] & ~row_q[0];
    step_o.rd         = col_q[0] & row_q[0];
    step_o.result     = col_q[0] & row_q[0];
    step_o.last       = col_end & row_end;
  end

  assign addr_o = col_q[CW-1:1];

endmodule

/* rtl/rbd_merge.sv */
`timescale 1ns / 1ps

module rbd_merge import rbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  step_t            step_i,
  input  pair_sum_t        line_i,
  output logic             ready_o,
  rbd_out_if.source        out_o
);

  logic              s1_valid_q;
  logic              s1_last_q;
  pair_sum_t         s1_pair_q;
  logic              out_valid_q;
  logic              out_last_q;
  pixel_t            out_pix_q;
  pixel_t            avg_d;
  logic              out_adv;
  logic [PAIR_W:0]   sum_r, sum_g, sum_b;

  assign out_adv = !out_valid_q || out_o.ready;
  assign ready_o = !s1_valid_q || out_adv;

  // Upper pair from the line store plus lower pair, divided by four.
  always_comb begin
    sum_r = {1'b0, line_i.red}   + {1'b0, s1_pair_q.red};
    sum_g = {1'b0, line_i.green} + {1'b0, s1_pair_q.green};
    sum_b = {1'b0, line_i.blue}  + {1'b0, s1_pair_q.blue};
    avg_d.red   = sum_r[PAIR_W:2];
    avg_d.green = sum_g[PAIR_W:2];
    avg_d.blue  = sum_b[PAIR_W:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= step_i.result;
      end else if (out_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_last_q <= step_i.last;
      s1_pair_q <= step_i.pair;
    end
    if (out_adv && s1_valid_q) begin
      out_pix_q  <= avg_d;
      out_last_q <= s1_last_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.red_out       = out_pix_q.red;
  assign out_o.green_out     = out_pix_q.green;
  assign out_o.blue_out      = out_pix_q.blue;
  assign out_o.alpha_out     = ALPHA_OPAQUE;
  assign out_o.last_of_image = out_last_q;

endmodule

/* rtl/rgba_box_downsample_2x2.sv */
`timescale 1ns / 1ps

// 2x2 box downsampler for a square RGB image streamed in raster order. One source
// pixel is taken per clock unless the sink stalls the output; the transaction that
// completes a block passes through the pair register, then the output register.
// Even rows write horizontal pair sums to a single-port line store of MAX_WIDTH/2
// entries, one write or one read per cycle; odd rows read them back. The store is
// not cleared after reset. cfg_wdata_i sets W = 4 * cfg_wdata_i (0 reads as
// 1, values above MAX_WIDTH/4 saturate); write it only between images.
// last_of_image marks the final output pixel, after which the scan restarts.
module rgba_box_downsample_2x2 import rbd_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [QUAD_W-1:0] cfg_wdata_i,
  rbd_in_if.sink            in_i,
  rbd_out_if.source         out_o
);

  localparam int QIW   = ($clog2(MAX_WIDTH / 4) > 1) ? $clog2(MAX_WIDTH / 4) : 1;
  localparam int CW    = QIW + 2;
  localparam int AW    = CW - 1;
  localparam int DEPTH = MAX_WIDTH / 2;

  step_t         step;
  logic [AW-1:0] addr;
  pair_sum_t     line_rd;
  logic          accept;
  logic          ready;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  rbd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .QIW       (QIW),
    .CW        (CW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .red_i       (in_i.red_in),
    .green_i     (in_i.green_in),
    .blue_i      (in_i.blue_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_o      (step),
    .addr_o      (addr)
  );

  rbd_line_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (accept && step.wr),
    .re_i    (accept && step.rd),
    .addr_i  (addr),
    .wdata_i (step.pair),
    .rdata_o (line_rd)
  );

  rbd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .step_i  (step),
    .line_i  (line_rd),
    .ready_o (ready),
    .out_o   (out_o)
  );

  // Input stalls only when the pair stage and the output register are full and the sink is not ready.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output backpressure");

  // After the final pixel of an image the scan stands at the top-left corner.
  a_image_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step.last) |=> (addr == '0 && !step.wr && !step.rd))
    else $error("scan did not wrap after last pixel");

  // A block-completing transaction reaches the output unless the sink stalls.
  a_result_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step.result) ##1 out_o.ready |=> out_o.valid)
    else $error("result lost between pair stage and output");

  // Hold the result and its payload while the sink stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable({out_o.red_out,
      out_o.green_out, out_o.blue_out, out_o.last_of_image})))
    else $error("output changed while stalled");

endmodule
